### rtl/core/ssd_pkg.sv
// Shared types and constants of the subsequence seed dynamic-program core.
package ssd_pkg;

  localparam int MAX_SUBSEQ_DEF = 16;
  localparam int ANGLES_DEF     = 8;

  localparam int SUM_W   = 38;
  localparam int SEQ_W   = 32;
  localparam int WGT_W   = 31;
  localparam int POS_W   = 4;
  localparam int LET_W   = 2;
  localparam int FANG_W  = 3;
  localparam int KLEN_W  = 7;
  localparam int SLEN_W  = 5;
  localparam int CIDX_W  = 2;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 40;

  localparam logic [KLEN_W-1:0] KMER_LEN_RST   = 7'd24;
  localparam logic [SLEN_W-1:0] SUBSEQ_LEN_RST = 5'd16;

  // Input command codes carried in in_tuser
  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_ROT    = 2'd1,
    CMD_PUSH   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_KMER_LEN   = 2'd0,
    CFG_SUBSEQ_LEN = 2'd1
  } cfg_idx_t;

  // Operation kinds passed from front to back
  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_ROT    = 2'd1,
    OP_PUSH   = 2'd2
  } op_kind_t;

  // Decoded operation; sign is {negate_prior, subtract_weight}
  typedef struct packed {
    op_kind_t            kind;
    logic [POS_W-1:0]    pos;
    logic [LET_W-1:0]    letter;
    logic [FANG_W-1:0]   angle;
    logic [WGT_W-1:0]    weight;
    logic [1:0]          sign;
    logic [FANG_W-1:0]   rot;
  } op_t;

  // One cell of the dynamic-program row (sums are two's complement)
  typedef struct packed {
    logic              reach;
    logic [SUM_W-1:0]  min_sum;
    logic [SUM_W-1:0]  max_sum;
    logic [SEQ_W-1:0]  min_seq;
    logic [SEQ_W-1:0]  max_seq;
  } cell_t;

  // Append one base to a packed subsequence
  function automatic logic [SEQ_W-1:0] seq_append(input logic [SEQ_W-1:0] seq,
                                                  input logic [LET_W-1:0] ltr);
    return {seq[SEQ_W-LET_W-1:0], ltr};
  endfunction

endpackage

### rtl/core/ssd_front.sv
// Front end: accepts input transactions, filters and decodes them, small op queue.
module ssd_front #(
  parameter int MAX_SUBSEQ = ssd_pkg::MAX_SUBSEQ_DEF,
  parameter int ANGLES     = ssd_pkg::ANGLES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [ssd_pkg::IN_DW-1:0] in_tdata,
  input  logic [1:0]                in_tuser,
  output ssd_pkg::op_t              q_op,
  output logic                      q_valid,
  input  logic                      q_pop
);

  localparam int QD = 2;

  ssd_pkg::cmd_t   cmd;
  ssd_pkg::op_t    dec_op;
  logic            keep;
  logic            push;
  ssd_pkg::op_t    q_mem_r [QD];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;

  // Rotation reduced modulo ANGLES by repeated compare and subtract
  function automatic logic [ssd_pkg::FANG_W-1:0] rot_mod(
      input logic [ssd_pkg::FANG_W-1:0] r);
    logic [ssd_pkg::FANG_W-1:0] v;
    v = r;
    for (int n = 0; n < 8; n++) begin
      if (32'(v) >= ANGLES) v = v - ssd_pkg::FANG_W'(ANGLES);
    end
    return v;
  endfunction

  // Decode and range check
  always_comb begin
    cmd           = ssd_pkg::cmd_t'(in_tuser);
    dec_op.pos    = in_tdata[3:0];
    dec_op.letter = in_tdata[5:4];
    dec_op.angle  = in_tdata[8:6];
    dec_op.weight = in_tdata[39:9];
    dec_op.sign   = {in_tdata[40], in_tdata[41]};
    dec_op.rot    = rot_mod(in_tdata[44:42]);
    dec_op.kind   = ssd_pkg::OP_PUSH;
    keep          = 1'b0;
    unique case (cmd)
      ssd_pkg::CMD_WEIGHT: begin
        dec_op.kind = ssd_pkg::OP_WEIGHT;
        keep = (32'(dec_op.pos) < MAX_SUBSEQ) && (32'(dec_op.angle) < ANGLES);
      end
      ssd_pkg::CMD_ROT: begin
        dec_op.kind = ssd_pkg::OP_ROT;
        keep = 32'(dec_op.pos) < MAX_SUBSEQ;
      end
      ssd_pkg::CMD_PUSH: begin
        dec_op.kind = ssd_pkg::OP_PUSH;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_tready = (cnt_r != 2'(QD));
  assign push      = in_tvalid && in_tready && keep;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_op      = q_mem_r[rd_ptr_r];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= dec_op;
  end

endmodule

### rtl/core/ssd_lane.sv
// One row lane (one subsequence length): tables, cell storage, update pipeline.
module ssd_lane #(
  parameter int ANGLES = ssd_pkg::ANGLES_DEF,
  parameter int LANE   = 1,
  localparam int ANG_W = (ANGLES > 1) ? $clog2(ANGLES) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            tbl_we,
  input  ssd_pkg::op_t                    tbl_op,
  input  logic                            step_valid,
  input  logic [ANG_W-1:0]                step_idx,
  input  logic [ssd_pkg::LET_W-1:0]       letter,
  input  logic                            active,
  input  logic                            commit,
  input  logic                            clear,
  input  ssd_pkg::cell_t                  prev_cell,
  input  logic [ANG_W-1:0]                rd_idx,
  output ssd_pkg::cell_t                  rd_cell,
  output logic [ANG_W-1:0]                req_idx
);

  localparam int MEM_D  = 4 * ANGLES;
  localparam int MEM_AW = $clog2(MEM_D);
  localparam int EW     = ssd_pkg::WGT_W + 2;

  logic [EW-1:0]             tbl_mem [MEM_D];
  logic [ANG_W-1:0]          rot_r [4];
  ssd_pkg::cell_t            cur_r [ANGLES];
  logic [ANGLES-1:0]         cur_reach_r;
  ssd_pkg::cell_t            nxt_r [ANGLES];
  logic [ANGLES-1:0]         nxt_reach_r;
  logic                      wsel, rsel;
  logic [MEM_AW-1:0]         wr_addr, rd_addr;
  logic [ANG_W-1:0]          rot;
  logic [ANG_W:0]            q_wide;

  // stage 1
  logic                      v1_r;
  logic [ANG_W-1:0]          s1_r;
  logic [EW-1:0]             w1_r;
  ssd_pkg::cell_t            own1_r, prev1_r;
  logic                      own1_reach_r;
  // stage 2
  logic                      v2_r;
  logic [ANG_W-1:0]          s2_r;
  logic signed [ssd_pkg::SUM_W-1:0] a2_r, b2_r;
  logic [ssd_pkg::SEQ_W-1:0] qa2_r, qb2_r;
  logic                      cand2_r;
  ssd_pkg::cell_t            own2_r;
  logic                      own2_reach_r;
  // stage 3
  logic                      v3_r;
  logic [ANG_W-1:0]          s3_r;
  logic signed [ssd_pkg::SUM_W-1:0] cmin3_r, cmax3_r;
  logic [ssd_pkg::SEQ_W-1:0] qmin3_r, qmax3_r;
  logic                      cand3_r;
  ssd_pkg::cell_t            own3_r;
  logic                      own3_reach_r;

  logic signed [ssd_pkg::SUM_W-1:0] pa, pb, wv, sa, sb;
  ssd_pkg::cell_t            mrg;

  // Table writes addressed to this lane
  assign wsel    = (32'(tbl_op.pos) == LANE - 1);
  assign wr_addr = MEM_AW'(32'(tbl_op.letter) * ANGLES + 32'(tbl_op.angle));
  assign rd_addr = MEM_AW'(32'(letter) * ANGLES + 32'(step_idx));
  assign rsel    = tbl_we && wsel;

  always_ff @(posedge clk) begin
    if (rsel && tbl_op.kind == ssd_pkg::OP_WEIGHT)
      tbl_mem[wr_addr] <= {tbl_op.sign, tbl_op.weight};
    if (step_valid) w1_r <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rsel && tbl_op.kind == ssd_pkg::OP_ROT)
      rot_r[tbl_op.letter] <= ANG_W'(tbl_op.rot);
  end

  // Source angle in the previous length for target angle step_idx
  assign rot = rot_r[letter];
  always_comb begin
    if (step_idx >= rot) q_wide = {1'b0, step_idx} - {1'b0, rot};
    else q_wide = {1'b0, step_idx} + (ANG_W+1)'(ANGLES) - {1'b0, rot};
  end
  assign req_idx = q_wide[ANG_W-1:0];

  // Read port toward the next lane and the scan
  always_comb begin
    rd_cell       = cur_r[rd_idx];
    rd_cell.reach = cur_reach_r[rd_idx];
  end

  // Stage 1: fetch operands
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= step_valid;
    s1_r         <= step_idx;
    own1_r       <= cur_r[step_idx];
    own1_reach_r <= cur_reach_r[step_idx];
    prev1_r      <= prev_cell;
  end

  // Stage 2: sign and weight
  always_comb begin
    pa = $signed(prev1_r.min_sum);
    pb = $signed(prev1_r.max_sum);
    wv = $signed({7'd0, w1_r[ssd_pkg::WGT_W-1:0]});
    if (w1_r[EW-1]) begin
      pa = -pa;
      pb = -pb;
    end
    if (w1_r[EW-2]) begin
      sa = pa - wv;
      sb = pb - wv;
    end else begin
      sa = pa + wv;
      sb = pb + wv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    s2_r         <= s1_r;
    a2_r         <= sa;
    b2_r         <= sb;
    qa2_r        <= ssd_pkg::seq_append(prev1_r.min_seq, letter);
    qb2_r        <= ssd_pkg::seq_append(prev1_r.max_seq, letter);
    cand2_r      <= prev1_r.reach;
    own2_r       <= own1_r;
    own2_reach_r <= own1_reach_r;
  end

  // Stage 3: order candidate pair
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    s3_r         <= s2_r;
    cand3_r      <= cand2_r;
    own3_r       <= own2_r;
    own3_reach_r <= own2_reach_r;
    if (a2_r < b2_r) begin
      cmin3_r <= a2_r; qmin3_r <= qa2_r;
      cmax3_r <= b2_r; qmax3_r <= qb2_r;
    end else begin
      cmin3_r <= b2_r; qmin3_r <= qb2_r;
      cmax3_r <= a2_r; qmax3_r <= qa2_r;
    end
  end

  // Merge with the cell that skips this base
  always_comb begin
    mrg       = own3_r;
    mrg.reach = own3_reach_r;
    if (cand3_r) begin
      if (!own3_reach_r || cmin3_r < $signed(own3_r.min_sum)) begin
        mrg.min_sum = cmin3_r;
        mrg.min_seq = qmin3_r;
      end
      if (!own3_reach_r || cmax3_r > $signed(own3_r.max_sum)) begin
        mrg.max_sum = cmax3_r;
        mrg.max_seq = qmax3_r;
      end
      mrg.reach = 1'b1;
    end
    if (!active) mrg.reach = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      nxt_r[s3_r]       <= mrg;
      nxt_reach_r[s3_r] <= mrg.reach;
    end
  end

  // Row commit and clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_reach_r <= '0;
    end else if (clear) begin
      cur_reach_r <= '0;
    end else if (commit) begin
      cur_reach_r <= nxt_reach_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) cur_r <= nxt_r;
  end

endmodule

### rtl/core/ssd_back.sv
// Back end: push sequencer, lane array, final scan and result register.
module ssd_back #(
  parameter int MAX_SUBSEQ = ssd_pkg::MAX_SUBSEQ_DEF,
  parameter int ANGLES     = ssd_pkg::ANGLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ssd_pkg::KLEN_W-1:0]  kmer_len,
  input  logic [ssd_pkg::SLEN_W-1:0]  subseq_len,
  input  ssd_pkg::op_t                q_op,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ssd_pkg::OUT_DW-1:0]  out_tdata,
  output logic [0:0]                  out_tuser
);

  localparam int ANG_W    = (ANGLES > 1) ? $clog2(ANGLES) : 1;
  localparam int CNT_W    = $clog2(ANGLES + 3);
  localparam int B_W      = $clog2(MAX_SUBSEQ + 1);
  localparam int RUN_LAST = ANGLES + 2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_COMMIT = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [ssd_pkg::KLEN_W-1:0]   bc_r, i_r, i_nxt;
  logic [ssd_pkg::LET_W-1:0]    let_r;
  logic [MAX_SUBSEQ:1]          active_r, active_nxt;
  logic                         emit_r;
  logic [B_W-1:0]               b_r, b_nxt;
  logic                         tbl_we, step_valid, commit, clear, emit_go;
  logic [ANG_W-1:0]             step_idx;

  ssd_pkg::cell_t               lane_rd [MAX_SUBSEQ+1];
  logic [ANG_W-1:0]             rd_idx  [MAX_SUBSEQ+1];
  logic [ANG_W-1:0]             lane_req [1:MAX_SUBSEQ];

  // scan state
  logic                         sc_v_r;
  logic [ANG_W-1:0]             sc_z_r;
  ssd_pkg::cell_t               sc_cell_r;
  logic                         found_r, stop_r;
  logic [ssd_pkg::SEQ_W-1:0]    seed_r;
  logic [ANG_W-1:0]             ang_r;
  logic signed [ssd_pkg::SUM_W-1:0] ans_r;
  logic                         f_n, st_n;
  logic [ssd_pkg::SEQ_W-1:0]    sd_n;
  logic [ANG_W-1:0]             an_n;
  logic signed [ssd_pkg::SUM_W-1:0] as_n, mag;

  logic                         out_valid_r;
  logic [ssd_pkg::SEQ_W-1:0]    out_seed_r;
  logic [ssd_pkg::FANG_W-1:0]   out_ang_r;
  logic                         out_found_r;

  // Per-push bounds
  assign i_nxt = bc_r + 7'd1;
  always_comb begin
    if (32'(subseq_len) > MAX_SUBSEQ) b_nxt = B_W'(MAX_SUBSEQ);
    else b_nxt = B_W'(subseq_len);
  end

  for (genvar j = 1; j <= MAX_SUBSEQ; j++) begin : g_act
    assign active_nxt[j] = (8'(j) <= 8'(i_nxt)) && (8'(j) <= 8'(b_nxt)) &&
                           (9'(j) + 9'(kmer_len) >= 9'(i_nxt) + 9'(b_nxt));
  end

  assign q_pop      = (state_r == ST_IDLE) && q_valid;
  assign tbl_we     = q_pop && (q_op.kind != ssd_pkg::OP_PUSH);
  assign step_valid = (state_r == ST_RUN) && (32'(cnt_r) < ANGLES);
  assign step_idx   = cnt_r[ANG_W-1:0];
  assign commit     = (state_r == ST_COMMIT);
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_tready);
  assign clear      = emit_go;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bc_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && q_op.kind == ssd_pkg::OP_PUSH) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (32'(cnt_r) == RUN_LAST) state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          bc_r  <= i_r;
          cnt_r <= '0;
          state_r <= emit_r ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (32'(cnt_r) == ANGLES) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            bc_r    <= '0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Push context
  always_ff @(posedge clk) begin
    if (q_pop && q_op.kind == ssd_pkg::OP_PUSH) begin
      i_r      <= i_nxt;
      let_r    <= q_op.letter;
      active_r <= active_nxt;
      emit_r   <= (i_nxt >= kmer_len);
      b_r      <= b_nxt;
    end
  end

  // Length zero row: only angle zero reachable, all sums zero
  always_comb begin
    lane_rd[0]       = '0;
    lane_rd[0].reach = (rd_idx[0] == '0);
  end

  // Read index routing: scan angle while scanning, neighbor request otherwise; the top lane always reads step_idx
  for (genvar j = 0; j <= MAX_SUBSEQ; j++) begin : g_idx
    if (j == MAX_SUBSEQ) begin : g_top
      assign rd_idx[j] = step_idx;
    end else begin : g_mid
      assign rd_idx[j] = (state_r == ST_SCAN) ? step_idx : lane_req[j+1];
    end
  end

  for (genvar j = 1; j <= MAX_SUBSEQ; j++) begin : g_lane
    ssd_lane #(
      .ANGLES (ANGLES),
      .LANE   (j)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .tbl_we     (tbl_we),
      .tbl_op     (q_op),
      .step_valid (step_valid),
      .step_idx   (step_idx),
      .letter     (let_r),
      .active     (active_r[j]),
      .commit     (commit),
      .clear      (clear),
      .prev_cell  (lane_rd[j-1]),
      .rd_idx     (rd_idx[j]),
      .rd_cell    (lane_rd[j]),
      .req_idx    (lane_req[j])
    );
  end

  // Scan fetch: one angle of the seed-length row per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) sc_v_r <= 1'b0;
    else sc_v_r <= (state_r == ST_SCAN) && (32'(cnt_r) < ANGLES);
    sc_z_r    <= step_idx;
    sc_cell_r <= lane_rd[b_r];
  end

  // Scan selection: first nonzero magnitude wins, ties stay on the min side
  always_comb begin
    f_n  = found_r;
    sd_n = seed_r;
    an_n = ang_r;
    as_n = ans_r;
    st_n = stop_r;
    mag  = $signed(sc_cell_r.min_sum);
    if (mag < 0) mag = -mag;
    if (sc_v_r && sc_cell_r.reach && !stop_r) begin
      if (!f_n) begin
        f_n  = 1'b1;
        sd_n = sc_cell_r.min_seq;
        an_n = sc_z_r;
      end
      if (as_n < mag) begin
        as_n = mag;
        sd_n = sc_cell_r.min_seq;
        an_n = sc_z_r;
      end
      if (as_n < $signed(sc_cell_r.max_sum)) begin
        as_n = $signed(sc_cell_r.max_sum);
        sd_n = sc_cell_r.max_seq;
        an_n = sc_z_r;
      end
      st_n = (as_n > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      stop_r  <= 1'b0;
    end else if (commit) begin
      found_r <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      found_r <= f_n;
      stop_r  <= st_n;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      seed_r <= '0;
      ang_r  <= '0;
      ans_r  <= '0;
    end else begin
      seed_r <= sd_n;
      ang_r  <= an_n;
      ans_r  <= as_n;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_seed_r  <= seed_r;
      out_ang_r   <= ssd_pkg::FANG_W'(ang_r);
      out_found_r <= found_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'd0, out_ang_r, out_seed_r};
  assign out_tuser[0] = out_found_r;

  // Checks
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("queue popped while a push is in progress");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && 32'(cnt_r) == RUN_LAST) |=> state_r == ST_COMMIT)
    else $error("row update did not end in commit");

  a_emit_clr: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (bc_r == '0 && out_valid_r))
    else $error("result load did not reset the base count");

  a_found_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && found_r) |=> found_r)
    else $error("found flag dropped during scan");

endmodule

### rtl/core/subsequence_seed_dp_core.sv
// Top level of the subsequence seed dynamic-program core.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_tvalid/in_tready  | in_tuser: cmd; in_tdata: table entry, base
//  out     | out_tvalid/out_tready| out_tdata: seed, angle; out_tuser: found
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A table write is applied when the back end pops it. In a base push each lane
// walks its ANGLES cells through a three-stage update, then commits; the last
// base of a k-mer adds an angle scan. Reset is synchronous; no clearing pass is
// needed. A two-entry queue lets input transactions arrive while a push runs; a
// held result stalls the next result load and, with it, the back end.
module subsequence_seed_dp_core #(
  parameter int MAX_SUBSEQ = ssd_pkg::MAX_SUBSEQ_DEF,
  parameter int ANGLES     = ssd_pkg::ANGLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [3:0] position, [5:4] letter, [8:6] angle, [39:9] weight,
  // [40] negate_prior, [41] subtract_weight, [44:42] rotation, zero fill
  input  logic [ssd_pkg::IN_DW-1:0]   in_tdata,
  // [1:0] cmd
  input  logic [1:0]                  in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [31:0] seed, [34:32] seed_angle, zero fill
  output logic [ssd_pkg::OUT_DW-1:0]  out_tdata,
  // [0] found
  output logic [0:0]                  out_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ssd_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [ssd_pkg::KLEN_W-1:0]  cfg_data
);

  logic [ssd_pkg::KLEN_W-1:0] kmer_len_r;
  logic [ssd_pkg::SLEN_W-1:0] subseq_len_r;
  ssd_pkg::op_t               q_op;
  logic                       q_valid, q_pop;
  logic                       cfg_we;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r   <= ssd_pkg::KMER_LEN_RST;
      subseq_len_r <= ssd_pkg::SUBSEQ_LEN_RST;
    end else if (cfg_we) begin
      case (ssd_pkg::cfg_idx_t'(cfg_index))
        ssd_pkg::CFG_KMER_LEN:   kmer_len_r   <= cfg_data;
        ssd_pkg::CFG_SUBSEQ_LEN: subseq_len_r <= cfg_data[ssd_pkg::SLEN_W-1:0];
        default: ;
      endcase
    end
  end

  ssd_front #(
    .MAX_SUBSEQ (MAX_SUBSEQ),
    .ANGLES     (ANGLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_op      (q_op),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  ssd_back #(
    .MAX_SUBSEQ (MAX_SUBSEQ),
    .ANGLES     (ANGLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .kmer_len   (kmer_len_r),
    .subseq_len (subseq_len_r),
    .q_op       (q_op),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### verif/tb_top.sv
// Testbench for the subsequence seed dynamic-program core: directed and random tests.
`timescale 1ns / 1ps

module tb_top;

  localparam int NPOS   = ssd_pkg::MAX_SUBSEQ_DEF;
  localparam int NANG   = ssd_pkg::ANGLES_DEF;
  localparam int NCELL  = (NPOS + 1) * NANG;
  localparam int SETTLE = 64;
  localparam int LIMIT  = 400000;

  typedef struct {
    logic [ssd_pkg::SEQ_W-1:0]  seed;
    logic [ssd_pkg::FANG_W-1:0] angle;
    logic                       found;
  } seed_res_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [ssd_pkg::IN_DW-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [ssd_pkg::OUT_DW-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [ssd_pkg::CIDX_W-1:0] cfg_index;
  logic [ssd_pkg::KLEN_W-1:0] cfg_data;

  subsequence_seed_dp_core uut (.*);

  // Shadow state of the core
  logic [ssd_pkg::WGT_W-1:0]  wgt_tab [NPOS*4*NANG];
  logic [1:0]                 sgn_tab [NPOS*4*NANG];
  logic [ssd_pkg::FANG_W-1:0] rot_tab [NPOS*4];
  longint            lo_sum [NCELL], hi_sum [NCELL], lo_old [NCELL], hi_old [NCELL];
  logic [ssd_pkg::SEQ_W-1:0] lo_seq [NCELL], hi_seq [NCELL];
  logic [ssd_pkg::SEQ_W-1:0] lo_sold [NCELL], hi_sold [NCELL];
  bit                reach [NCELL], reach_old [NCELL];
  int                base_cnt, kmer_len, subseq_len;

  seed_res_t seed_q[$];
  int  errors;
  int  cycles;
  bit  no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit take_gap();
    return !no_idle && ($urandom_range(99) < 37);
  endfunction

  function automatic void clear_row();
    for (int c = 0; c < NCELL; c++) begin
      lo_sum[c] = 0; hi_sum[c] = 0; lo_seq[c] = '0; hi_seq[c] = '0; reach[c] = 0;
    end
    reach[0] = 1;
  endfunction

  // Advance one row for a pushed base; emit a seed at the end of the k-mer
  function automatic void push_base(input logic [ssd_pkg::LET_W-1:0] ltr);
    int b, lo_j, hi_j, tb, c, pc, e;
    logic [ssd_pkg::FANG_W-1:0] rot, z;
    longint mn, mx, w, a, bb, cmin, cmax, ans, m;
    logic [ssd_pkg::SEQ_W-1:0] smn, smx, qmin, qmax;
    bit have;
    seed_res_t r;
    base_cnt = (base_cnt + 1) & 7'h7f;
    b = (subseq_len > NPOS) ? NPOS : subseq_len;
    lo_j = base_cnt - (kmer_len - b);
    if (lo_j < 1) lo_j = 1;
    hi_j = (base_cnt < b) ? base_cnt : b;
    lo_old = lo_sum; hi_old = hi_sum; lo_sold = lo_seq; hi_sold = hi_seq;
    reach_old = reach;
    clear_row();
    for (int j = lo_j; j <= hi_j; j++) begin
      tb = (j - 1) * 4 + ltr;
      rot = rot_tab[tb];
      for (int q = 0; q < NANG; q++) begin
        z = ssd_pkg::FANG_W'(q + rot);
        c = j * NANG + z;
        pc = (j - 1) * NANG + q;
        have = 0; mn = 0; mx = 0; smn = '0; smx = '0;
        if (reach_old[c]) begin
          mn = lo_old[c]; smn = lo_sold[c]; mx = hi_old[c]; smx = hi_sold[c]; have = 1;
        end
        if (reach_old[pc]) begin
          e = tb * NANG + z;
          w = longint'(wgt_tab[e]);
          a = lo_old[pc]; bb = hi_old[pc];
          if (sgn_tab[e][1]) begin a = -a; bb = -bb; end
          if (sgn_tab[e][0]) begin a -= w; bb -= w; end
          else begin a += w; bb += w; end
          if (a < bb) begin
            cmin = a; qmin = {lo_sold[pc][ssd_pkg::SEQ_W-3:0], ltr};
            cmax = bb; qmax = {hi_sold[pc][ssd_pkg::SEQ_W-3:0], ltr};
          end else begin
            cmin = bb; qmin = {hi_sold[pc][ssd_pkg::SEQ_W-3:0], ltr};
            cmax = a; qmax = {lo_sold[pc][ssd_pkg::SEQ_W-3:0], ltr};
          end
          if (!have || cmin < mn) begin mn = cmin; smn = qmin; end
          if (!have || cmax > mx) begin mx = cmax; smx = qmax; end
          have = 1;
        end
        reach[c] = have; lo_sum[c] = mn; lo_seq[c] = smn; hi_sum[c] = mx; hi_seq[c] = smx;
      end
    end
    if (base_cnt >= kmer_len) begin
      r.found = 0; r.seed = '0; r.angle = '0; ans = 0;
      for (int zz = 0; zz < NANG; zz++) begin
        c = b * NANG + zz;
        if (!reach[c]) continue;
        if (!r.found) begin
          r.found = 1; r.seed = lo_seq[c]; r.angle = ssd_pkg::FANG_W'(zz);
        end
        m = (lo_sum[c] < 0) ? -lo_sum[c] : lo_sum[c];
        if (ans < m) begin
          ans = m; r.seed = lo_seq[c]; r.angle = ssd_pkg::FANG_W'(zz);
        end
        if (ans < hi_sum[c]) begin
          ans = hi_sum[c]; r.seed = hi_seq[c]; r.angle = ssd_pkg::FANG_W'(zz);
        end
        if (ans > 0) break;
      end
      seed_q.insert(seed_q.size(), r);
      clear_row();
      base_cnt = 0;
    end
  endfunction

  // Update the shadow for one accepted input transaction
  function automatic void apply_item(input ssd_pkg::cmd_t cmd,
                                     input logic [ssd_pkg::IN_DW-1:0] d);
    int e;
    case (cmd)
      ssd_pkg::CMD_WEIGHT: begin
        e = (d[3:0] * 4 + d[5:4]) * NANG + d[8:6];
        wgt_tab[e] = d[39:9];
        sgn_tab[e] = {d[40], d[41]};
      end
      ssd_pkg::CMD_ROT:  rot_tab[d[3:0] * 4 + d[5:4]] = d[44:42];
      ssd_pkg::CMD_PUSH: push_base(d[5:4]);
      default: ;
    endcase
  endfunction

  // Send one input transaction
  task automatic send_item(input ssd_pkg::cmd_t cmd, input logic [ssd_pkg::IN_DW-1:0] d);
    if (take_gap()) begin
      in_tvalid <= 1'b0;
      while (take_gap()) @(posedge clk);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    apply_item(cmd, d);
  endtask

  function automatic logic [ssd_pkg::IN_DW-1:0] pack_in(
      input int pos, input int ltr, input int ang, input logic [ssd_pkg::WGT_W-1:0] w,
      input bit neg, input bit sub, input int rot);
    return {3'b000, rot[2:0], sub, neg, w, ang[2:0], ltr[1:0], pos[3:0]};
  endfunction

  task automatic write_weight(input int pos, ltr, ang,
                              input logic [ssd_pkg::WGT_W-1:0] w,
                              input bit neg, sub);
    send_item(ssd_pkg::CMD_WEIGHT, pack_in(pos, ltr, ang, w, neg, sub, 0));
  endtask

  task automatic push(input int ltr);
    send_item(ssd_pkg::CMD_PUSH,
              pack_in($urandom_range(15), ltr, $urandom_range(7),
                      ssd_pkg::WGT_W'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)), $urandom_range(7)));
  endtask

  // Let every queued result drain and the back end go quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (seed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input ssd_pkg::cfg_idx_t idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[ssd_pkg::KLEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == ssd_pkg::CFG_KMER_LEN) kmer_len = val & 7'h7f;
    else subseq_len = val & 5'h1f;
  endtask

  task automatic set_lengths(input int k, input int s);
    wait_idle();
    write_cfg(ssd_pkg::CFG_KMER_LEN, k);
    write_cfg(ssd_pkg::CFG_SUBSEQ_LEN, s);
  endtask

  // Fill every table entry so no read ever hits an unwritten one
  task automatic test_table_load();
    for (int p = 0; p < NPOS; p++)
      for (int l = 0; l < 4; l++) begin
        send_item(ssd_pkg::CMD_ROT, pack_in(p, l, 0, '0, 1'b0, 1'b0, $urandom_range(7)));
        for (int a = 0; a < NANG; a++)
          write_weight(p, l, a, ssd_pkg::WGT_W'($urandom), 1'($urandom_range(1)),
                       1'($urandom_range(1)));
      end
    write_weight(0, 1, 0, '1, 1'b1, 1'b1);
    write_weight(0, 1, 1, '0, 1'b0, 1'b0);
  endtask

  task automatic test_directed();
    // full k-mer at reset lengths
    for (int i = 0; i < 24; i++) push(i & 3);
    // all magnitudes zero: seed taken from the min side of the first reachable angle
    set_lengths(1, 1);
    for (int a = 0; a < NANG; a++) write_weight(0, 2, a, '0, 1'(a & 1), 1'((a >> 1) & 1));
    push(2);
    push(1);
    // zero seed length
    wait_idle();
    write_cfg(ssd_pkg::CFG_SUBSEQ_LEN, 0);
    push(3);
    // seed longer than the k-mer, plus an unknown command
    set_lengths(3, 8);
    send_item(ssd_pkg::CMD_NONE, '1);
    push(0); push(1); push(2);
    // zero k-mer length: every base ends a k-mer, but no lane is active
    set_lengths(0, 1);
    push(3);
  endtask

  // Random item: mostly pushes, some table rewrites, rare unknown commands
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 80) push($urandom_range(3));
    else if (r < 94)
      write_weight($urandom_range(15), $urandom_range(3), $urandom_range(7),
                   ($urandom_range(9) == 0) ? 31'h7fffffff : ssd_pkg::WGT_W'($urandom),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    else if (r < 99)
      send_item(ssd_pkg::CMD_ROT, pack_in($urandom_range(15), $urandom_range(3), 0, '0,
                                          1'b0, 1'b0, $urandom_range(7)));
    else send_item(ssd_pkg::CMD_NONE, ssd_pkg::IN_DW'({$urandom, $urandom}));
  endtask

  task automatic test_random();
    int klens[9] = '{1, 64, 16, 5, 100, 8, 20, 2, 12};
    int slens[9] = '{1, 16, 16, 0, 31, 8, 20, 2, 5};
    for (int ph = 0; ph < 9; ph++) begin
      set_lengths(klens[ph], slens[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 80; n++) begin
        random_item();
        if (ph == 6 && n == 40) wait_idle();
      end
    end
    no_idle = 0;
    set_lengths(24, 16);
    for (int n = 0; n < 50; n++) random_item();
  endtask

  // Result checker
  always @(posedge clk) begin
    seed_res_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (seed_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        x = seed_q.pop_front();
        if (out_tdata[31:0] !== x.seed) begin
          $error("seed: expected %h actual %h", x.seed, out_tdata[31:0]); errors++;
        end
        if (out_tdata[34:32] !== x.angle) begin
          $error("seed_angle: expected %0d actual %0d", x.angle, out_tdata[34:32]); errors++;
        end
        if (out_tuser[0] !== x.found) begin
          $error("found: expected %0d actual %0d", x.found, out_tuser[0]); errors++;
        end
      end
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) out_tready <= no_idle || ($urandom_range(99) >= 37);

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("subsequence_seed_dp_core verification failed");
      $finish;
    end
  end

  initial begin
    clk = 1'b0; rst_n = 1'b0;
    in_tvalid <= 1'b0; in_tdata <= '0; in_tuser <= '0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    errors = 0; cycles = 0; no_idle = 0;
    base_cnt = 0; kmer_len = 24; subseq_len = 16;
    clear_row();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_load();
    test_directed();
    test_random();
    wait_idle();
    if (seed_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("subsequence_seed_dp_core verification clean");
    end else begin
      $display("subsequence_seed_dp_core verification failed");
    end
    $finish;
  end

endmodule
